[src/dmc_pkg.sv]
// Shared constants and types for the direct-mapped cache lookup block.
`timescale 1ns / 1ps

package dmc_pkg;

  // Address and field widths
  localparam int ADDR_W       = 32;
  localparam int OFF_W        = 5;
  localparam int IDXB_W       = 4;
  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int LINE_INDEX_W = 10;
  localparam int COUNT_W      = 32;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 80;
  localparam int OUT_TUSER_W  = 1;

  // Width of the tag shift amount: offset plus index can reach 46
  localparam int SHAMT_W = 6;

  // Reset values of the configuration registers
  localparam logic [OFF_W-1:0]  OFFSET_RESET = 5'd4;
  localparam logic [IDXB_W-1:0] INDEX_RESET  = 4'd6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Default number of lines and queue depth between front and back
  localparam int MAX_LINES_DEF = 1024;
  localparam int Q_DEPTH       = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_BITS = 1'b0,
    REG_INDEX_BITS  = 1'b1
  } cfg_reg_t;

  // Status from the back end to the front end
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

[src/direct_mapped_cache_lookup.sv]
// Top level of the direct-mapped cache hit/miss lookup.
//
//  Channel | Dir | Signals                      | Contents (lowest bit first)
//  --------+-----+------------------------------+---------------------------------------------
//  s       | in  | s_tvalid s_tready s_tdata    | address[31:0]
//  m       | out | m_tvalid m_tready m_tdata    | line_index[9:0] hit_count[41:10]
//          |     | m_tuser                      |   access_count[73:42], zero pad; tuser: hit
//  cfg     | in  | cfg_we cfg_index cfg_data    | 0: offset_bits[4:0], 1: index_bits[3:0]
//
// One item per cycle sustained while the output is not stalled; an item passes from the queue
// to the lookup stage, then to the result register. The tag RAM is read at the edge that takes
// the item from the queue and written as the result is registered; a write to the same line is
// forwarded to the following lookup. After reset the tag RAM is cleared, one line a cycle, over
// all 2**floor(log2(MAX_LINES)) lines (1024 by default); s_tready stays low until then.
// A stalled output holds the lookup stage; the two-entry queue keeps accepting until it is full.
`timescale 1ns / 1ps

module direct_mapped_cache_lookup #(
  parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [dmc_pkg::IN_TDATA_W-1:0]    s_tdata,   // address
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [dmc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // line_index, hit_count, access_count
  output logic [dmc_pkg::OUT_TUSER_W-1:0]   m_tuser,   // hit
  input  logic                              cfg_we,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmc_pkg::CFG_W-1:0]         cfg_data
);

  localparam int MIB     = $clog2(MAX_LINES + 1) - 1;
  localparam int AW      = (MIB > 0) ? MIB : 1;
  localparam int Q_W     = dmc_pkg::ADDR_W + AW;
  localparam int USED_W  = dmc_pkg::LINE_INDEX_W + 2 * dmc_pkg::COUNT_W;
  localparam int PAD_W   = dmc_pkg::OUT_TDATA_W - USED_W;

  dmc_pkg::back_status_t status;

  logic           q_push;
  logic [Q_W-1:0] q_push_data;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  logic [Q_W-1:0] q_data;

  logic                               out_hit;
  logic [dmc_pkg::LINE_INDEX_W-1:0]   out_line_index;
  logic [dmc_pkg::COUNT_W-1:0]        out_hit_count;
  logic [dmc_pkg::COUNT_W-1:0]        out_access_count;

  dmc_front #(
    .MAX_LINES (MAX_LINES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .status    (status),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  dmc_fifo #(
    .W (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  dmc_back #(
    .MAX_LINES (MAX_LINES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .status           (status),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_hit          (out_hit),
    .out_line_index   (out_line_index),
    .out_hit_count    (out_hit_count),
    .out_access_count (out_access_count)
  );

  // Pack the result
  always_comb begin
    m_tdata = {{PAD_W{1'b0}}, out_access_count, out_hit_count, out_line_index};
    m_tuser = out_hit;
  end

endmodule

[src/dmc_fifo.sv]
// Small FIFO that decouples the address front end from the tag lookup back end.
`timescale 1ns / 1ps

module dmc_fifo #(
  parameter int W = 42
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  localparam int DEPTH = dmc_pkg::Q_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Status
  always_comb begin
    full      = (count == CNT_W'(DEPTH));
    pop_valid = (count != '0);
    pop_data  = slots[rd_ptr];
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

[src/dmc_front.sv]
// Front end: holds the split configuration, accepts addresses, splits them into index and tag.
`timescale 1ns / 1ps

module dmc_front #(
  parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dmc_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  dmc_pkg::back_status_t            status,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [dmc_pkg::ADDR_W+((($clog2(MAX_LINES+1)-1) > 0) ?
                ($clog2(MAX_LINES+1)-1) : 1)-1:0] q_data
);

  localparam int MIB = $clog2(MAX_LINES + 1) - 1;
  localparam int AW  = (MIB > 0) ? MIB : 1;

  logic [dmc_pkg::OFF_W-1:0]   offset_bits;
  logic [dmc_pkg::IDXB_W-1:0]  index_bits;

  logic [dmc_pkg::ADDR_W-1:0]  addr;
  logic [dmc_pkg::OFF_W-1:0]   ib;
  logic [dmc_pkg::ADDR_W-1:0]  idx_mask;
  logic [dmc_pkg::ADDR_W-1:0]  idx_full;
  logic [dmc_pkg::ADDR_W-1:0]  tag;
  logic [dmc_pkg::SHAMT_W-1:0] tag_shift;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= dmc_pkg::OFFSET_RESET;
      index_bits  <= dmc_pkg::INDEX_RESET;
    end else if (cfg_we) begin
      case (dmc_pkg::cfg_reg_t'(cfg_index))
        dmc_pkg::REG_OFFSET_BITS: offset_bits <= cfg_data;
        dmc_pkg::REG_INDEX_BITS:  index_bits  <= cfg_data[dmc_pkg::IDXB_W-1:0];
        default: ;
      endcase
    end
  end

  // Split the address: clamp the index width to the lines that exist
  always_comb begin
    addr = s_tdata[dmc_pkg::ADDR_W-1:0];
    if ({1'b0, index_bits} > dmc_pkg::OFF_W'(MIB)) begin
      ib = dmc_pkg::OFF_W'(MIB);
    end else begin
      ib = {1'b0, index_bits};
    end
    idx_mask  = ~({dmc_pkg::ADDR_W{1'b1}} << ib);
    idx_full  = (addr >> offset_bits) & idx_mask;
    tag_shift = dmc_pkg::SHAMT_W'(offset_bits) + dmc_pkg::SHAMT_W'(ib);
    tag       = addr >> tag_shift;
  end

  // Accept while the back end is not clearing and the queue has room
  always_comb begin
    s_tready = !status.clearing && !q_full;
    q_push   = s_tvalid && s_tready;
    q_data   = {tag, idx_full[AW-1:0]};
  end

endmodule

[src/dmc_back.sv]
// Back end: tag RAM lookup with write forwarding, hit and access counters, output register.
`timescale 1ns / 1ps

module dmc_back #(
  parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  logic [dmc_pkg::ADDR_W+((($clog2(MAX_LINES+1)-1) > 0) ?
                ($clog2(MAX_LINES+1)-1) : 1)-1:0] q_data,
  output logic                              q_pop,
  output dmc_pkg::back_status_t             status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [dmc_pkg::LINE_INDEX_W-1:0]  out_line_index,
  output logic [dmc_pkg::COUNT_W-1:0]       out_hit_count,
  output logic [dmc_pkg::COUNT_W-1:0]       out_access_count
);

  localparam int MIB     = $clog2(MAX_LINES + 1) - 1;
  localparam int AW      = (MIB > 0) ? MIB : 1;
  localparam int LINES   = 1 << MIB;
  localparam int ENTRY_W = dmc_pkg::ADDR_W + 1;
  localparam int EXT_W   = (AW > dmc_pkg::LINE_INDEX_W) ? AW : dmc_pkg::LINE_INDEX_W;

  // Tag RAM: valid bit on top of the stored tag
  logic [ENTRY_W-1:0] mem [LINES];
  logic [ENTRY_W-1:0] mem_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // Clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Lookup stage
  logic                      b_valid;
  logic [AW-1:0]             b_idx;
  logic [dmc_pkg::ADDR_W-1:0] b_tag;
  logic                      fwd_sel;
  logic [dmc_pkg::ADDR_W-1:0] fwd_tag;
  logic                      b_adv;

  logic [AW-1:0]              q_idx;
  logic [dmc_pkg::ADDR_W-1:0] q_tag;
  logic                       entry_valid;
  logic [dmc_pkg::ADDR_W-1:0] entry_tag;
  logic                       hit;
  logic [EXT_W-1:0]           idx_ext;

  logic [dmc_pkg::COUNT_W-1:0] hits_total;
  logic [dmc_pkg::COUNT_W-1:0] accesses_total;
  logic [dmc_pkg::COUNT_W-1:0] hits_total_next;
  logic [dmc_pkg::COUNT_W-1:0] accesses_total_next;

  // Handshakes, forwarding and hit decision
  always_comb begin
    q_idx       = q_data[AW-1:0];
    q_tag       = q_data[AW+dmc_pkg::ADDR_W-1:AW];
    b_adv       = b_valid && (!out_valid || out_ready);
    q_pop       = q_valid && !clearing && (!b_valid || b_adv);
    // Entry written at the same edge as our read comes from the forward register
    entry_valid = fwd_sel ? 1'b1 : mem_q[dmc_pkg::ADDR_W];
    entry_tag   = fwd_sel ? fwd_tag : mem_q[dmc_pkg::ADDR_W-1:0];
    hit         = entry_valid && (entry_tag == b_tag);
    idx_ext     = EXT_W'(b_idx);

    hits_total_next = hits_total;
    if (hit && (hits_total != dmc_pkg::COUNT_MAX)) begin
      hits_total_next = hits_total + 1'b1;
    end
    accesses_total_next = accesses_total;
    if (accesses_total != dmc_pkg::COUNT_MAX) begin
      accesses_total_next = accesses_total + 1'b1;
    end

    // Every access leaves the line valid with its own tag
    mem_we    = clearing || b_adv;
    mem_waddr = clearing ? clr_addr : b_idx;
    mem_wdata = clearing ? '0 : {1'b1, b_tag};

    status.clearing = clearing;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing       <= 1'b1;
      clr_addr       <= '0;
      b_valid        <= 1'b0;
      fwd_sel        <= 1'b0;
      out_valid      <= 1'b0;
      hits_total     <= '0;
      accesses_total <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(LINES - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (q_pop) begin
        b_valid <= 1'b1;
        fwd_sel <= b_adv && (b_idx == q_idx);
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        out_valid      <= 1'b1;
        hits_total     <= hits_total_next;
        accesses_total <= accesses_total_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Lookup payload and result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_idx   <= q_idx;
      b_tag   <= q_tag;
      fwd_tag <= b_tag;
    end
    if (b_adv) begin
      out_hit          <= hit;
      out_line_index   <= idx_ext[dmc_pkg::LINE_INDEX_W-1:0];
      out_hit_count    <= hits_total_next;
      out_access_count <= accesses_total_next;
    end
  end

  // Tag RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      mem_q <= mem[q_idx];
    end
  end

endmodule

[sim/direct_mapped_cache_lookup_test.sv]
// Self-checking testbench for the direct-mapped cache lookup: directed table, then random phases.
`timescale 1ns / 1ps

module direct_mapped_cache_lookup_test;

  localparam int LINES         = dmc_pkg::MAX_LINES_DEF;
  localparam int MAX_IDX_BITS  = $clog2(LINES + 1) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int PLAN_ROWS     = 30;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 100;
  localparam int POOL_SIZE     = 12;

  typedef enum logic {ROW_LOOKUP, ROW_WRITE} row_kind_t;

  // One row of the directed plan: a register write or a lookup, optionally with
  // the hit flag and line index typed in
  typedef struct packed {
    row_kind_t                         kind;
    dmc_pkg::cfg_reg_t                 target;
    logic [dmc_pkg::CFG_W-1:0]         value;
    logic [dmc_pkg::ADDR_W-1:0]        address;
    logic                              typed;
    logic                              hit;
    logic [dmc_pkg::LINE_INDEX_W-1:0]  line;
  } plan_row_t;

  typedef struct packed {
    logic                              hit;
    logic [dmc_pkg::LINE_INDEX_W-1:0]  line;
    logic [dmc_pkg::COUNT_W-1:0]       hits;
    logic [dmc_pkg::COUNT_W-1:0]       accesses;
  } lookup_result_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [dmc_pkg::IN_TDATA_W-1:0]   s_tdata;   // address
  logic                             m_tvalid;
  logic                             m_tready;
  logic [dmc_pkg::OUT_TDATA_W-1:0]  m_tdata;   // line_index, hit_count, access_count
  logic [dmc_pkg::OUT_TUSER_W-1:0]  m_tuser;   // hit
  logic                             cfg_we;
  logic [dmc_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [dmc_pkg::CFG_W-1:0]        cfg_data;

  // Mirror of the block's state
  logic [dmc_pkg::OFF_W-1:0]        model_offset_bits;
  logic [dmc_pkg::IDXB_W-1:0]       model_index_bits;
  bit                               model_valid [LINES];
  logic [63:0]                      model_tag [LINES];
  logic [dmc_pkg::COUNT_W-1:0]      model_hits;
  logic [dmc_pkg::COUNT_W-1:0]      model_accesses;

  lookup_result_t                   pending_lookups[$];
  int                               failures = 0;
  bit                               quiet = 1'b0;

  logic [dmc_pkg::ADDR_W-1:0]       addr_pool [POOL_SIZE];

  plan_row_t plan [PLAN_ROWS] = '{
    // Reset split: 4 offset bits, 6 index bits
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h0000_0000, 1'b1, 1'b0, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h0000_0000, 1'b1, 1'b1, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h0000_000F, 1'b1, 1'b1, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h0000_0010, 1'b1, 1'b0, 10'd1},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 10'd63},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 10'd63},
    // Conflict on line 0, then the evicted block again
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h0000_0400, 1'b1, 1'b0, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h0000_0000, 1'b1, 1'b0, 10'd0},
    // Byte blocks, all lines in use
    '{ROW_WRITE,  dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h0,         1'b0, 1'b0, 10'd0},
    '{ROW_WRITE,  dmc_pkg::REG_INDEX_BITS,  5'd10, 32'h0,         1'b0, 1'b0, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h0000_03FF, 1'b1, 1'b0, 10'd1023},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 10'd1023},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h5555_5555, 1'b0, 1'b0, 10'd0},
    // Index too wide: clamps to ten bits, so the previous tag still matches
    '{ROW_WRITE,  dmc_pkg::REG_INDEX_BITS,  5'd15, 32'h0,         1'b0, 1'b0, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 10'd1023},
    // Offset too wide: index and tag shrink toward zero
    '{ROW_WRITE,  dmc_pkg::REG_OFFSET_BITS, 5'd31, 32'h0,         1'b0, 1'b0, 10'd0},
    '{ROW_WRITE,  dmc_pkg::REG_INDEX_BITS,  5'd0,  32'h0,         1'b0, 1'b0, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h8000_0000, 1'b0, 1'b0, 10'd0},
    // Largest legal offset with the widest index
    '{ROW_WRITE,  dmc_pkg::REG_OFFSET_BITS, 5'd16, 32'h0,         1'b0, 1'b0, 10'd0},
    '{ROW_WRITE,  dmc_pkg::REG_INDEX_BITS,  5'd10, 32'h0,         1'b0, 1'b0, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'hFFFF_0000, 1'b0, 1'b0, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'hAAAA_AAAA, 1'b0, 1'b0, 10'd0},
    // Single line, the whole address is the tag
    '{ROW_WRITE,  dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h0,         1'b0, 1'b0, 10'd0},
    '{ROW_WRITE,  dmc_pkg::REG_INDEX_BITS,  5'd0,  32'h0,         1'b0, 1'b0, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h1234_5678, 1'b0, 1'b0, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h1234_5678, 1'b1, 1'b1, 10'd0},
    '{ROW_LOOKUP, dmc_pkg::REG_OFFSET_BITS, 5'd0,  32'h1234_5679, 1'b1, 1'b0, 10'd0},
    // Back to the reset split
    '{ROW_WRITE,  dmc_pkg::REG_OFFSET_BITS, 5'd4,  32'h0,         1'b0, 1'b0, 10'd0},
    '{ROW_WRITE,  dmc_pkg::REG_INDEX_BITS,  5'd6,  32'h0,         1'b0, 1'b0, 10'd0}
  };

  direct_mapped_cache_lookup DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Split the address, compare against the mirrored line, update state and counters
  function automatic lookup_result_t predict_lookup(logic [dmc_pkg::ADDR_W-1:0] address);
    int unsigned              ob;
    int unsigned              ib;
    logic [63:0]              wide_addr;
    logic [63:0]              idx;
    logic [63:0]              tag;
    logic [MAX_IDX_BITS-1:0]  sel;
    lookup_result_t           r;
    ob = 32'(model_offset_bits);
    ib = (model_index_bits > MAX_IDX_BITS) ? MAX_IDX_BITS : 32'(model_index_bits);
    wide_addr = {32'b0, address};
    idx = (wide_addr >> ob) & ((64'd1 << ib) - 64'd1);
    tag = wide_addr >> (ob + ib);
    if (idx >= LINES) idx = '0;
    sel = idx[MAX_IDX_BITS-1:0];
    r.hit = model_valid[sel] && (model_tag[sel] == tag);
    if (r.hit) begin
      if (model_hits != dmc_pkg::COUNT_MAX) model_hits = model_hits + 1'b1;
    end else begin
      model_valid[sel] = 1'b1;
      model_tag[sel]   = tag;
    end
    if (model_accesses != dmc_pkg::COUNT_MAX) model_accesses = model_accesses + 1'b1;
    r.line     = idx[dmc_pkg::LINE_INDEX_W-1:0];
    r.hits     = model_hits;
    r.accesses = model_accesses;
    return r;
  endfunction

  // Drop valid and hold until every expected result has arrived
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_register(dmc_pkg::cfg_reg_t target,
                                logic [dmc_pkg::CFG_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= target;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (target == dmc_pkg::REG_OFFSET_BITS) model_offset_bits = value;
    else model_index_bits = value[dmc_pkg::IDXB_W-1:0];
  endtask

  // Offer one address (after a random idle unless quiet), record its expectation, hold until accepted
  task automatic send_lookup(logic [dmc_pkg::ADDR_W-1:0] address, logic typed,
                             logic typed_hit, logic [dmc_pkg::LINE_INDEX_W-1:0] typed_line);
    lookup_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tdata  <= address;
    s_tvalid <= 1'b1;
    r = predict_lookup(address);
    if (typed) begin
      r.hit  = typed_hit;
      r.line = typed_line;
    end
    pending_lookups.push_back(r);
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // Stall the result side in random bursts, except in the quiet phase
  always begin
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    m_tready <= 1'b1;
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    lookup_result_t got;
    if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got.hit      = m_tuser[0];
      got.line     = m_tdata[9:0];
      got.hits     = m_tdata[41:10];
      got.accesses = m_tdata[73:42];
      if (pending_lookups.size() == 0) begin
        $display("%0t: result with nothing expected: hit %0b line %0d hits %0d accesses %0d",
                 $time, got.hit, got.line, got.hits, got.accesses);
        failures++;
      end else begin
        want = pending_lookups.pop_front();
        if (got.hit !== want.hit || got.line !== want.line ||
            got.hits !== want.hits || got.accesses !== want.accesses) begin
          $display("%0t: expected hit %0b line %0d hits %0d accesses %0d", $time,
                   want.hit, want.line, want.hits, want.accesses);
          $display("%0t:   actual hit %0b line %0d hits %0d accesses %0d", $time,
                   got.hit, got.line, got.hits, got.accesses);
          failures++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [dmc_pkg::ADDR_W-1:0] address;
    int                         k;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = dmc_pkg::REG_OFFSET_BITS;
    cfg_data  = '0;
    model_offset_bits = dmc_pkg::OFFSET_RESET;
    model_index_bits  = dmc_pkg::INDEX_RESET;
    model_hits        = '0;
    model_accesses    = '0;
    for (int i = 0; i < LINES; i++) begin
      model_valid[i] = 1'b0;
      model_tag[i]   = '0;
    end
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_WRITE) write_register(plan[i].target, plan[i].value);
      else send_lookup(plan[i].address, plan[i].typed, plan[i].hit, plan[i].line);
    end

    // Random phases, each under its own split; the last one runs without idling
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_register(dmc_pkg::REG_OFFSET_BITS, 5'd4);
          write_register(dmc_pkg::REG_INDEX_BITS, 5'd6);
        end
        1: begin
          write_register(dmc_pkg::REG_OFFSET_BITS, 5'd0);
          write_register(dmc_pkg::REG_INDEX_BITS, 5'd10);
        end
        3: begin
          write_register(dmc_pkg::REG_OFFSET_BITS, 5'd16);
          write_register(dmc_pkg::REG_INDEX_BITS, 5'd0);
        end
        default: begin
          write_register(dmc_pkg::REG_OFFSET_BITS, dmc_pkg::CFG_W'(
                         ($urandom_range(0, 3) == 0) ?
                         $urandom_range(17, 31) : $urandom_range(0, 16)));
          write_register(dmc_pkg::REG_INDEX_BITS,
                         dmc_pkg::CFG_W'($urandom_range(0, 15)));
        end
      endcase
      quiet = (p == PHASES - 1);
      // Working set: some entries are the previous one with a single bit in 20..31 flipped
      for (int j = 0; j < POOL_SIZE; j++) begin
        if (j > 0 && $urandom_range(0, 2) == 0)
          addr_pool[j] = addr_pool[j-1] ^ (32'h1 << $urandom_range(20, 31));
        else
          addr_pool[j] = $urandom();
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) drain_results();
        if ($urandom_range(0, 3) == 0) begin
          address = $urandom();
        end else begin
          k = $urandom_range(0, POOL_SIZE - 1);
          address = addr_pool[k] ^ $urandom_range(0, 15);
        end
        send_lookup(address, 1'b0, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
